/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion macros shared by the rtl files, empty for synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

/* src/drsg_pkg.sv */
// ----------------------------------------------------------------------------
// drsg_pkg
// types, constants and the sigmoid table of the diagonal recurrence core
// ----------------------------------------------------------------------------
package drsg_pkg;

  localparam int BATCH_ROWS_DEF = 4;
  localparam int HIDDEN_DIM_DEF = 256;

  localparam int H_W      = 16;
  localparam int GATED_W  = 18;
  localparam int SIG_W    = 16;
  localparam int SIG_DEPTH = 256;

  localparam logic signed [H_W-1:0]   H_MAX     = 16'sh7fff;
  localparam logic signed [H_W-1:0]   H_MIN     = 16'sh8000;
  localparam logic [GATED_W-1:0]      GATED_MAX = 18'h3ffff;
  localparam logic [16:0]             SIG_ONE   = 17'd65536;
  localparam logic [31:0]             EXP_STEP_Q32 = 32'd4162825044;

  typedef struct packed {
    logic [1:0]            batch_index;
    logic [7:0]            dim_index;
    logic signed [H_W-1:0] x_value;
    logic [15:0]           decay;
    logic signed [H_W-1:0] bias;
    logic                  first_step;
    logic signed [H_W-1:0] initial_h;
  } drsg_in_t;

  typedef struct packed {
    logic [1:0]            out_batch_index;
    logic [7:0]            out_dim_index;
    logic signed [H_W-1:0] hidden;
    logic [GATED_W-1:0]    gated;
    logic                  saturated;
  } drsg_out_t;

  typedef logic [SIG_DEPTH-1:0][SIG_W-1:0] sig_table_t;

  // sigmoid at bin midpoints, e^-|m| by repeated rounded products,
  // reciprocal by restoring long division
  function automatic sig_table_t build_sigmoid();
    sig_table_t  tbl;
    logic [63:0] step2;
    logic [63:0] e;
    logic [63:0] den;
    logic [63:0] num;
    logic [63:0] rem;
    logic [16:0] q;
    logic [16:0] s;
    int          i;
    int          j;
    step2 = (64'(EXP_STEP_Q32) * 64'(EXP_STEP_Q32) + 64'h8000_0000) >> 32;
    e     = 64'(EXP_STEP_Q32);
    for (j = 0; j < SIG_DEPTH / 2; j++) begin
      den = 64'h1_0000_0000 + e;
      num = 64'h1_0000_0000_0000 + (den >> 1);
      rem = num >> 17;
      q   = '0;
      for (i = 16; i >= 0; i--) begin
        rem = {rem[62:0], num[i]};
        if (rem >= den) begin
          rem  = rem - den;
          q[i] = 1'b1;
        end
      end
      s = (q > 17'd65535) ? 17'd65535 : q;
      tbl[SIG_DEPTH / 2 + j]     = s[SIG_W-1:0];
      tbl[SIG_DEPTH / 2 - 1 - j] = SIG_W'(SIG_ONE - s);
      e = (e * step2 + 64'h8000_0000) >> 32;
    end
    return tbl;
  endfunction

  localparam sig_table_t SIGMOID_TABLE = build_sigmoid();

endpackage

/* src/drsg_ram.sv */
// ----------------------------------------------------------------------------
// drsg_ram
// simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module drsg_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* src/diagonal_recurrence_selfgate_forward_core.sv */
// ----------------------------------------------------------------------------
// diagonal_recurrence_selfgate_forward_core
// per-element diagonal recurrence h = decay*(x + h_prev) + bias with a
// self-gated output h*h*sigmoid(h)
// ----------------------------------------------------------------------------
// The block takes one transaction per cycle while in_stall is low and presents
// its results on the output in order. Hidden values live in one ram of
// BATCH_ROWS*HIDDEN_DIM entries, read when a transaction is accepted and written
// back when it leaves stage 2; a transaction that reads the entry the transaction
// just ahead of it will write waits, a conflict with the transaction two ahead
// is forwarded unless a stall holds it there. Output stalls hold the occupied stages.
// After reset a clearing pass zeroes the ram, one entry a cycle, all
// BATCH_ROWS*HIDDEN_DIM entries (1024 at the default size), and in_stall stays
// high until it ends. The sigmoid comes from a 256-entry constant table.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module diagonal_recurrence_selfgate_forward_core
  import drsg_pkg::*;
#(
  parameter int BATCH_ROWS = BATCH_ROWS_DEF,
  parameter int HIDDEN_DIM = HIDDEN_DIM_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  drsg_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output drsg_out_t out_data
);

  localparam int STORE_DEPTH = BATCH_ROWS * HIDDEN_DIM;
  localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(STORE_DEPTH - 1);

  // clearing pass
  logic              clr_active_r, clr_active_nxt;
  logic [ADDR_W-1:0] clr_cnt_r, clr_cnt_nxt;

  // ram ports
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [H_W-1:0]    ram_wdata;
  logic [H_W-1:0]    ram_rdata;

  // input side
  logic [31:0]       in_addr_full;
  logic [ADDR_W-1:0] in_addr;
  logic              in_range;
  logic              in_accept;
  logic              hazard;
  logic              fwd_hit;

  // stage 1: ram data arrives
  logic                  s1_valid_r;
  drsg_in_t              s1_item_r;
  logic [ADDR_W-1:0]     s1_addr_r;
  logic                  s1_in_range_r;
  logic                  fwd_v_r;
  logic signed [H_W-1:0] fwd_h_r;
  logic signed [H_W-1:0] s1_prev;
  logic signed [16:0]    s1_sum;
  logic signed [16:0]    s1_dec;
  logic signed [33:0]    s2_prod_nxt;

  // stage 2: round, bias, saturate, write back
  logic                  s2_valid_r;
  logic [1:0]            s2_bi_r;
  logic [7:0]            s2_di_r;
  logic signed [H_W-1:0] s2_bias_r;
  logic [ADDR_W-1:0]     s2_addr_r;
  logic                  s2_in_range_r;
  logic signed [33:0]    s2_prod_r;
  logic signed [33:0]    s2_rnd;
  logic signed [17:0]    s2_hq;
  logic signed [18:0]    s2_hb;
  logic signed [H_W-1:0] s3_h_nxt;
  logic                  s3_sat_nxt;
  logic                  wr_item;

  // stage 3: square and table lookup
  logic                  s3_valid_r;
  logic [1:0]            s3_bi_r;
  logic [7:0]            s3_di_r;
  logic signed [H_W-1:0] s3_h_r;
  logic                  s3_sat_r;
  logic [7:0]            s3_idx;
  logic [H_W-1:0]        s3_mag;
  logic [31:0]           s4_sq_nxt;
  logic [SIG_W-1:0]      s4_sig_nxt;

  // stage 4: gate product
  logic                  s4_valid_r;
  logic [1:0]            s4_bi_r;
  logic [7:0]            s4_di_r;
  logic signed [H_W-1:0] s4_h_r;
  logic                  s4_sat_r;
  logic [31:0]           s4_sq_r;
  logic [SIG_W-1:0]      s4_sig_r;
  logic [47:0]           s4_prod;
  logic [19:0]           s4_g;
  drsg_out_t             out_data_nxt;

  // output register
  logic                  out_valid_r;
  drsg_out_t             out_data_r;

  // stage flow
  logic out_free, s4_free, s3_free, s2_free, s1_free;

  assign out_free = !out_valid_r || !out_stall;
  assign s4_free  = !s4_valid_r || out_free;
  assign s3_free  = !s3_valid_r || s4_free;
  assign s2_free  = !s2_valid_r || s3_free;
  assign s1_free  = !s1_valid_r || s2_free;

  // input decode and hazard check
  assign in_addr_full = 32'(in_data.batch_index) * 32'(HIDDEN_DIM) + 32'(in_data.dim_index);
  assign in_addr      = in_addr_full[ADDR_W-1:0];
  assign in_range     = (32'(in_data.batch_index) < 32'(BATCH_ROWS)) &&
                        (32'(in_data.dim_index) < 32'(HIDDEN_DIM));

  always_comb begin
    hazard = 1'b0;
    if (!in_data.first_step && in_range) begin
      if (s1_valid_r && s1_in_range_r && (s1_addr_r == in_addr)) begin
        hazard = 1'b1;
      end
      if (s2_valid_r && s2_in_range_r && !s3_free && (s2_addr_r == in_addr)) begin
        hazard = 1'b1;
      end
    end
  end

  assign in_stall  = clr_active_r || !s1_free || hazard;
  assign in_accept = in_valid && !in_stall;
  assign wr_item   = s2_valid_r && s3_free && s2_in_range_r;
  assign fwd_hit   = wr_item && (s2_addr_r == in_addr);

  // clearing pass
  assign clr_active_nxt = clr_active_r && (clr_cnt_r != ADDR_LAST);
  assign clr_cnt_nxt    = clr_active_r ? clr_cnt_r + 1'b1 : clr_cnt_r;

  // ram
  assign ram_we    = clr_active_r || wr_item;
  assign ram_waddr = clr_active_r ? clr_cnt_r : s2_addr_r;
  assign ram_wdata = clr_active_r ? '0 : s3_h_nxt;

  drsg_ram #(
    .WIDTH (H_W),
    .DEPTH (STORE_DEPTH),
    .AW    (ADDR_W)
  ) u_hidden_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (in_accept),
    .raddr (in_addr),
    .rdata (ram_rdata)
  );

  // stage 1
  always_comb begin
    if (s1_item_r.first_step) begin
      s1_prev = s1_item_r.initial_h;
    end else if (!s1_in_range_r) begin
      s1_prev = '0;
    end else if (fwd_v_r) begin
      s1_prev = fwd_h_r;
    end else begin
      s1_prev = ram_rdata;
    end
  end

  assign s1_sum      = 17'(s1_item_r.x_value) + 17'(s1_prev);
  assign s1_dec      = {1'b0, s1_item_r.decay};
  assign s2_prod_nxt = s1_dec * s1_sum;

  // stage 2
  assign s2_rnd = s2_prod_r + 34'sd32768;
  assign s2_hq  = s2_rnd[33:16];
  assign s2_hb  = 19'(s2_hq) + 19'(s2_bias_r);

  always_comb begin
    if (s2_hb > 19'(H_MAX)) begin
      s3_h_nxt   = H_MAX;
      s3_sat_nxt = 1'b1;
    end else if (s2_hb < 19'(H_MIN)) begin
      s3_h_nxt   = H_MIN;
      s3_sat_nxt = 1'b1;
    end else begin
      s3_h_nxt   = s2_hb[H_W-1:0];
      s3_sat_nxt = 1'b0;
    end
  end

  // stage 3
  assign s3_idx     = {~s3_h_r[15], s3_h_r[14:8]};
  assign s3_mag     = s3_h_r[15] ? H_W'(-17'(s3_h_r)) : s3_h_r;
  assign s4_sq_nxt  = 32'(s3_mag) * 32'(s3_mag);
  assign s4_sig_nxt = SIGMOID_TABLE[s3_idx];

  // stage 4
  assign s4_prod = 48'(s4_sq_r) * 48'(s4_sig_r);
  assign s4_g    = 20'((s4_prod + 48'h800_0000) >> 28);

  always_comb begin
    out_data_nxt.out_batch_index = s4_bi_r;
    out_data_nxt.out_dim_index   = s4_di_r;
    out_data_nxt.hidden          = s4_h_r;
    out_data_nxt.saturated       = s4_sat_r;
    out_data_nxt.gated           = (s4_g > 20'(GATED_MAX)) ? GATED_MAX : s4_g[GATED_W-1:0];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_cnt_r    <= '0;
      s1_valid_r   <= 1'b0;
      s2_valid_r   <= 1'b0;
      s3_valid_r   <= 1'b0;
      s4_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      fwd_v_r      <= 1'b0;
    end else begin
      clr_active_r <= clr_active_nxt;
      clr_cnt_r    <= clr_cnt_nxt;
      if (s1_free) begin
        s1_valid_r <= in_accept;
      end
      if (s2_free) begin
        s2_valid_r <= s1_valid_r;
      end
      if (s3_free) begin
        s3_valid_r <= s2_valid_r;
      end
      if (s4_free) begin
        s4_valid_r <= s3_valid_r;
      end
      if (out_free) begin
        out_valid_r <= s4_valid_r;
      end
      if (in_accept) begin
        fwd_v_r <= fwd_hit;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_item_r     <= in_data;
      s1_addr_r     <= in_addr;
      s1_in_range_r <= in_range;
      fwd_h_r       <= s3_h_nxt;
    end
    if (s2_free) begin
      s2_bi_r       <= s1_item_r.batch_index;
      s2_di_r       <= s1_item_r.dim_index;
      s2_bias_r     <= s1_item_r.bias;
      s2_addr_r     <= s1_addr_r;
      s2_in_range_r <= s1_in_range_r;
      s2_prod_r     <= s2_prod_nxt;
    end
    if (s3_free) begin
      s3_bi_r  <= s2_bi_r;
      s3_di_r  <= s2_di_r;
      s3_h_r   <= s3_h_nxt;
      s3_sat_r <= s3_sat_nxt;
    end
    if (s4_free) begin
      s4_bi_r  <= s3_bi_r;
      s4_di_r  <= s3_di_r;
      s4_h_r   <= s3_h_r;
      s4_sat_r <= s3_sat_r;
      s4_sq_r  <= s4_sq_nxt;
      s4_sig_r <= s4_sig_nxt;
    end
    if (out_free) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `ASSERT_ALWAYS(a_no_accept_in_clear, clk, rst_n, !(clr_active_r && in_accept), "transaction accepted during clearing pass")
  `ASSERT_NEXT(a_clear_once, clk, rst_n, !clr_active_r, !clr_active_r, "clearing pass restarted")
  `ASSERT_ALWAYS(a_sat_at_bound, clk, rst_n, (out_valid_r && out_data_r.saturated) |-> (out_data_r.hidden == H_MAX || out_data_r.hidden == H_MIN), "saturated flag without bound value")
  `ASSERT_ALWAYS(a_zero_gate, clk, rst_n, (out_valid_r && out_data_r.hidden == '0) |-> (out_data_r.gated == '0), "nonzero gate for zero hidden value")

endmodule

/* dv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// self-checking testbench of the diagonal recurrence self-gated forward core
// ----------------------------------------------------------------------------
// Sends directed edge cases, then random streams that follow a few
// (batch, dim) pairs through many steps. Other random items pick any pair
// and fill every field at random. Each accepted transaction runs through a local
// predictor that keeps its own hidden store and sigmoid table. Results are
// compared field by field, in order. Both sides idle in random bursts. The
// receiver also holds off once for a long stretch, so that the core backs up.
// ----------------------------------------------------------------------------
module tb_top;
  import drsg_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_RANDOM   = 450;
  localparam int TAIL_ITEMS = 60;
  localparam int LIMIT      = 200000;
  localparam int STORE_N    = BATCH_ROWS_DEF * HIDDEN_DIM_DEF;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  drsg_in_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  drsg_out_t out_data;

  drsg_in_t  pending_q[$];
  drsg_out_t expected_q[$];
  drsg_out_t want;
  logic signed [15:0] hidden_mem [STORE_N];
  logic [15:0] sig_lut [256];

  int n_errors = 0;
  int n_accepted = 0;
  int cycles = 0;
  int gap_left = 0;
  int stall_left = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  logic idle_en;

  diagonal_recurrence_selfgate_forward_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // sigmoid at bin midpoints, e^-|m| stepped by rounded products
  function automatic void build_sig_lut();
    logic [63:0] step2;
    logic [63:0] e;
    logic [63:0] den;
    logic [63:0] s;
    step2 = (64'(EXP_STEP_Q32) * 64'(EXP_STEP_Q32) + 64'h8000_0000) >> 32;
    e = 64'(EXP_STEP_Q32);
    for (int j = 0; j < 128; j++) begin
      den = 64'h1_0000_0000 + e;
      s = ((64'd1 << 48) + (den >> 1)) / den;
      if (s > 64'd65535) s = 64'd65535;
      sig_lut[128 + j] = s[15:0];
      sig_lut[127 - j] = 16'(64'd65536 - s);
      e = (e * step2 + 64'h8000_0000) >> 32;
    end
  endfunction

  function automatic drsg_out_t step_recurrence(drsg_in_t t);
    drsg_out_t r;
    logic signed [63:0] prev;
    logic signed [63:0] prod;
    logic signed [63:0] h;
    logic [63:0] hu;
    logic [63:0] mag;
    logic [63:0] g;
    int unsigned addr;
    bit in_rng;
    in_rng = (t.batch_index < BATCH_ROWS_DEF) && (t.dim_index < HIDDEN_DIM_DEF);
    addr = t.batch_index * HIDDEN_DIM_DEF + t.dim_index;
    prev = 0;
    if (t.first_step) prev = t.initial_h;
    else if (in_rng) prev = hidden_mem[addr];
    prod = $signed({48'd0, t.decay}) * (t.x_value + prev);
    // round to nearest, ties toward +inf
    h = (prod + 64'sd32768) >>> 16;
    h = h + t.bias;
    r.saturated = 1'b0;
    if (h > 64'sd32767) begin
      h = 64'sd32767;
      r.saturated = 1'b1;
    end else if (h < -64'sd32768) begin
      h = -64'sd32768;
      r.saturated = 1'b1;
    end
    if (in_rng) hidden_mem[addr] = h[15:0];
    hu = h + 64'sd32768;
    mag = (h < 0) ? -h : h;
    g = (mag * mag * sig_lut[hu[15:8]] + (64'd1 << 27)) >> 28;
    if (g > 64'(GATED_MAX)) g = 64'(GATED_MAX);
    r.out_batch_index = t.batch_index;
    r.out_dim_index = t.dim_index;
    r.hidden = h[15:0];
    r.gated = g[17:0];
    return r;
  endfunction

  function automatic drsg_in_t mk_elem(logic [1:0] b, logic [7:0] d, logic [15:0] x,
                                       logic [15:0] dc, logic [15:0] bs, logic f,
                                       logic [15:0] ih);
    drsg_in_t t;
    t.batch_index = b;
    t.dim_index = d;
    t.x_value = x;
    t.decay = dc;
    t.bias = bs;
    t.first_step = f;
    t.initial_h = ih;
    return t;
  endfunction

  task automatic check_field(string what, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, exp_v, act_v);
      n_errors++;
    end
  endtask

  assign idle_en = (cycles[8:7] != 2'b11) && (pending_q.size() > TAIL_ITEMS);

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_q.push_back(step_recurrence(in_data));
        n_accepted <= n_accepted + 1;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          in_valid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (pending_q.size() > 0) begin
          in_data <= pending_q.pop_front();
          in_valid <= 1'b1;
          if (idle_en && $urandom_range(0, 5) == 0) gap_left <= $urandom_range(1, 8);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, once
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (!hold_done && n_accepted >= 150) begin
      hold_left <= 64;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected transaction, expected none, actual %p", $time, out_data);
          n_errors++;
        end else begin
          want = expected_q.pop_front();
          check_field("out_batch_index", want.out_batch_index, out_data.out_batch_index);
          check_field("out_dim_index", want.out_dim_index, out_data.out_dim_index);
          check_field("hidden", 16'(want.hidden), 16'(out_data.hidden));
          check_field("gated", want.gated, out_data.gated);
          check_field("saturated", want.saturated, out_data.saturated);
        end
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left <= stall_left - 1;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        stall_left <= $urandom_range(0, 7);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    logic [1:0]  hot_b [6];
    logic [7:0]  hot_d [6];
    logic [15:0] dc;
    logic [15:0] bs;
    int          k;
    foreach (hidden_mem[i]) hidden_mem[i] = '0;
    build_sig_lut();

    // directed cases
    pending_q.push_back(mk_elem(2'd0, 8'd0, 16'h0000, 16'h0000, 16'h0000, 1'b0, 16'h0000));
    pending_q.push_back(mk_elem(2'd3, 8'd255, 16'h7fff, 16'hffff, 16'h7fff, 1'b1, 16'h7fff));
    pending_q.push_back(mk_elem(2'd3, 8'd255, 16'h8000, 16'hffff, 16'h8000, 1'b0, 16'h1234));
    pending_q.push_back(mk_elem(2'd3, 8'd255, 16'h0000, 16'hffff, 16'h0000, 1'b0, 16'h0000));
    pending_q.push_back(mk_elem(2'd3, 8'd254, 16'h8000, 16'hffff, 16'h0000, 1'b1, 16'h8000));
    pending_q.push_back(mk_elem(2'd3, 8'd255, 16'h0100, 16'h8000, 16'h0010, 1'b0, 16'h7fff));
    pending_q.push_back(mk_elem(2'd1, 8'd7, 16'h0001, 16'h8000, 16'h0000, 1'b1, 16'h0000));
    pending_q.push_back(mk_elem(2'd1, 8'd8, 16'hffff, 16'h8000, 16'h0000, 1'b1, 16'h0000));
    pending_q.push_back(mk_elem(2'd1, 8'd7, 16'h0003, 16'h8000, 16'h0000, 1'b0, 16'h0000));
    pending_q.push_back(mk_elem(2'd2, 8'd1, 16'h1234, 16'h0000, 16'h7fff, 1'b0, 16'h0000));
    pending_q.push_back(mk_elem(2'd2, 8'd2, 16'h4321, 16'h0000, 16'h8000, 1'b0, 16'h0000));
    pending_q.push_back(mk_elem(2'd2, 8'd1, 16'h0000, 16'hffff, 16'h0000, 1'b0, 16'h0000));
    pending_q.push_back(mk_elem(2'd2, 8'd2, 16'h0000, 16'hffff, 16'h0000, 1'b0, 16'h0000));
    pending_q.push_back(mk_elem(2'd0, 8'd128, 16'h7fff, 16'hffff, 16'h0000, 1'b1, 16'h8000));
    pending_q.push_back(mk_elem(2'd0, 8'd128, 16'h8000, 16'hffff, 16'h0000, 1'b1, 16'h7fff));
    pending_q.push_back(mk_elem(2'd0, 8'd129, 16'h7fff, 16'h8000, 16'h4000, 1'b1, 16'h7fff));
    pending_q.push_back(mk_elem(2'd0, 8'd129, 16'h8000, 16'h8000, 16'hc000, 1'b0, 16'h0000));
    pending_q.push_back(mk_elem(2'd0, 8'd129, 16'h0800, 16'hf000, 16'h0100, 1'b0, 16'h0000));
    pending_q.push_back(mk_elem(2'd0, 8'd0, 16'h1000, 16'hffff, 16'hf000, 1'b0, 16'h0000));
    pending_q.push_back(mk_elem(2'd0, 8'd0, 16'h0000, 16'h0001, 16'h0000, 1'b0, 16'h0000));

    // random streams, mostly on a few hot pairs
    for (int i = 0; i < 6; i++) begin
      hot_b[i] = 2'($urandom);
      hot_d[i] = (i < 2) ? 8'd5 : 8'($urandom);
    end
    for (int i = 0; i < N_RANDOM; i++) begin
      dc = ($urandom_range(0, 2) == 0) ? 16'($urandom) : 16'($urandom_range(16'hc000, 16'hffff));
      bs = ($urandom_range(0, 1) == 0) ? 16'($urandom)
                                       : 16'($urandom_range(0, 4095)) - 16'd2048;
      if ($urandom_range(0, 9) < 7) begin
        k = $urandom_range(0, 5);
        pending_q.push_back(mk_elem(hot_b[k], hot_d[k], 16'($urandom), dc, bs,
                                    ($urandom_range(0, 7) == 0), 16'($urandom)));
      end else begin
        pending_q.push_back(mk_elem(2'($urandom), 8'($urandom), 16'($urandom), dc, bs,
                                    1'($urandom), 16'($urandom)));
      end
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    do @(posedge clk);
    while (pending_q.size() != 0 || in_valid || expected_q.size() != 0);
    repeat (20) @(posedge clk);
    if (n_errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
